@@ rtl/bdec_pkg.sv @@
// ----------------------------------------------------------------------------
// bdec_pkg
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bdec_pkg;

    // Depth of the token queue between front and back; a power of two, at least 2
    localparam int BDEC_QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
    localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [3:0] LOW_NIBBLE_MASK = 4'hf;  // 0x0f
    localparam logic [1:0] LOW_PAIR_MASK   = 2'h3;  // 0x03

    // Token kinds handed from front to back; skipped characters never get one
    typedef enum logic [1:0] {
        TK_SEXTET = 2'd0,
        TK_PAD    = 2'd1,
        TK_END    = 2'd2
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [5:0] sextet;
    } t_token;

    // Position of the next sextet within its group of four
    typedef enum logic [3:0] {
        PH0 = 4'b0001,
        PH1 = 4'b0010,
        PH2 = 4'b0100,
        PH3 = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

@@ rtl/bdec_front.sv @@
// ----------------------------------------------------------------------------
// bdec_front
// Accepts characters, holds the space-as-plus setting and classifies each
// character into a sextet, pad or end token. Other characters are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire                  i_cfg_wr_data,
    input  wire                  i_char_valid,
    output logic                 o_char_ready,
    input  wire [7:0]            i_char,
    output logic                 o_tok_valid,
    input  wire                  i_tok_ready,
    output bdec_pkg::t_token     o_tok
);
    import bdec_pkg::*;

    logic r_space_plus;
    logic n_space_plus;
    logic w_keep;

    always_comb begin
        n_space_plus = r_space_plus;
        if (i_cfg_wr_en) begin
            n_space_plus = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_plus <= 1'b1;
        end else begin
            r_space_plus <= n_space_plus;
        end
    end

    always_comb begin
        o_tok.kind   = TK_SEXTET;
        o_tok.sextet = 6'd0;
        w_keep       = 1'b1;
        if (i_char == CHAR_NUL) begin
            o_tok.kind = TK_END;
        end else if (i_char == CHAR_PAD) begin
            o_tok.kind = TK_PAD;
        end else if (i_char inside {["A":"Z"]}) begin
            o_tok.sextet = 6'(i_char - 8'd65);
        end else if (i_char inside {["a":"z"]}) begin
            o_tok.sextet = 6'(i_char - 8'd71);
        end else if (i_char inside {["0":"9"]}) begin
            o_tok.sextet = 6'(i_char + 8'd4);
        end else if (i_char == CHAR_PLUS || (i_char == CHAR_SPACE && r_space_plus)) begin
            o_tok.sextet = SEXTET_PLUS;
        end else if (i_char == CHAR_SLASH) begin
            o_tok.sextet = SEXTET_SLASH;
        end else begin
            w_keep = 1'b0;
        end
    end

    // Drop skipped characters without waiting on the queue
    assign o_char_ready = i_tok_ready || !w_keep;
    assign o_tok_valid  = i_char_valid && w_keep;

endmodule

`default_nettype wire

@@ rtl/bdec_queue.sv @@
// ----------------------------------------------------------------------------
// bdec_queue
// Small register queue of tokens between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_queue #(
    parameter int DEPTH = bdec_pkg::BDEC_QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    output logic                 o_push_ready,
    input  bdec_pkg::t_token     i_push_tok,
    output logic                 o_pop_valid,
    input  wire                  i_pop_ready,
    output bdec_pkg::t_token     o_pop_tok
);
    import bdec_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);

    t_token        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [AW:0]   r_count;
    logic [AW:0]   n_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != FULL_COUNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_COUNT) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/bdec_back.sv @@
// ----------------------------------------------------------------------------
// bdec_back
// Packs sextets into bytes, tracks padding and reports status on the end
// token. Results sit in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_tok_valid,
    output logic                 o_tok_ready,
    input  bdec_pkg::t_token     i_tok,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic                 o_out_status
);
    import bdec_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_partial;
    logic [7:0] n_partial;
    logic       r_pad;
    logic       n_pad;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_byte;
    logic [7:0] n_out_byte;
    logic       r_out_last;
    logic       n_out_last;
    logic       r_out_status;
    logic       n_out_status;
    logic       w_pop;
    logic [5:0] w_v;

    assign o_tok_ready  = !r_out_valid || i_out_ready;
    assign w_pop        = i_tok_valid && o_tok_ready;
    assign w_v          = i_tok.sextet;
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

    always_comb begin
        n_phase      = r_phase;
        n_partial    = r_partial;
        n_pad        = r_pad;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        if (w_pop) begin
            case (i_tok.kind)
                TK_END: begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = 8'd0;
                    n_out_last   = 1'b1;
                    n_out_status = r_pad && (r_phase == PH0 || r_phase == PH1);
                    n_phase      = PH0;
                    n_partial    = 8'd0;
                    n_pad        = 1'b0;
                end
                TK_PAD: begin
                    n_pad = 1'b1;
                end
                TK_SEXTET: begin
                    // After padding, drop everything up to the end token
                    if (!r_pad) begin
                        n_out_last   = 1'b0;
                        n_out_status = 1'b0;
                        case (r_phase)
                            PH0: begin
                                n_partial = {w_v, 2'b00};
                                n_phase   = PH1;
                            end
                            PH1: begin
                                n_out_valid = 1'b1;
                                n_out_byte  = r_partial | {6'd0, w_v[5:4]};
                                n_partial   = {w_v[3:0] & LOW_NIBBLE_MASK, 4'd0};
                                n_phase     = PH2;
                            end
                            PH2: begin
                                n_out_valid = 1'b1;
                                n_out_byte  = r_partial | {4'd0, w_v[5:2]};
                                n_partial   = {w_v[1:0] & LOW_PAIR_MASK, 6'd0};
                                n_phase     = PH3;
                            end
                            PH3: begin
                                n_out_valid = 1'b1;
                                n_out_byte  = r_partial | {2'd0, w_v};
                                n_partial   = 8'd0;
                                n_phase     = PH0;
                            end
                            default: begin
                                n_phase = PH0;
                            end
                        endcase
                    end
                end
                default: begin
                    n_pad = r_pad;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH0;
            r_partial   <= 8'd0;
            r_pad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_partial   <= n_partial;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_tok.kind == TK_END) |=> (r_phase == PH0 && !r_pad && r_partial == 8'd0))
        else $error("end token did not clear stream state");

    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> r_out_last)
        else $error("status raised on a data item");

    a_pad_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && r_pad && i_tok.kind != TK_END) |=> ($stable(r_phase) && r_pad))
        else $error("state moved after padding");

    a_byte_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !r_pad && i_tok.kind == TK_SEXTET && r_phase == PH0) |=>
        (r_out_valid == $past(r_out_valid && !i_out_ready)))
        else $error("byte emitted on first sextet of a group");

endmodule

`default_nettype wire

@@ rtl/base64_stream_decoder.sv @@
// Path: an accepted character is classified combinationally, held as a token in
// the queue, then decoded by the back end into the output register.
// Throughput: one character per cycle, also while a result waits on m_axis_tready;
// the token queue absorbs short output stalls before s_axis_tready drops.
// Reset (i_rst_n low, synchronous): clears group phase, partial byte, pad flag and
// the queue; space_means_plus returns to 1.
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 character stream to byte stream decoder with end-of-string status.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = bdec_pkg::BDEC_QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire        i_cfg_wr_data,   // space_means_plus
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,    // [7:0] char_in
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] data_byte
    output logic       m_axis_tlast,    // is_end
    output logic       m_axis_tuser     // [0] status
);
    import bdec_pkg::*;

    logic   w_fr_valid;
    logic   w_fr_ready;
    t_token w_fr_tok;
    logic   w_bk_valid;
    logic   w_bk_ready;
    t_token w_bk_tok;

    bdec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char_valid  (s_axis_tvalid),
        .o_char_ready  (s_axis_tready),
        .i_char        (s_axis_tdata),
        .o_tok_valid   (w_fr_valid),
        .i_tok_ready   (w_fr_ready),
        .o_tok         (w_fr_tok)
    );

    bdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .i_push_tok   (w_fr_tok),
        .o_pop_valid  (w_bk_valid),
        .i_pop_ready  (w_bk_ready),
        .o_pop_tok    (w_bk_tok)
    );

    bdec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (w_bk_valid),
        .o_tok_ready  (w_bk_ready),
        .i_tok        (w_bk_tok),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream decoder. A driver sends a queue
// of characters (directed strings, random strings with padding,
// noise and stray bytes) under random input gaps. Each accepted character is
// decoded by a local model into the expected byte or end status. A monitor
// applies random output stalls and compares every output transfer with the
// oldest expected result. The space option is changed only while idle.
// ----------------------------------------------------------------------------

module tb_top;
    import bdec_pkg::*;

    localparam int    SETTLE_CYCLES = 12;
    localparam int    MAX_REPORTS   = 10;
    localparam int    PHASE_ITEMS   = 200;
    localparam logic  STATUS_OK      = 1'b0;
    localparam logic  STATUS_BAD_PAD = 1'b1;

    localparam logic [1:0] GRP_S0 = 2'd0;
    localparam logic [1:0] GRP_S1 = 2'd1;
    localparam logic [1:0] GRP_S2 = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
        logic       status;
    } t_dec_result;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] char_in
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] data_byte
    logic       m_axis_tlast;            // is_end
    logic       m_axis_tuser;            // [0] status

    base64_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Local decoder state
    logic       space_as_plus = 1'b1;
    logic [1:0] grp_phase     = GRP_S0;
    logic [7:0] high_bits     = 8'h00;
    logic       pad_seen      = 1'b0;

    logic [7:0]  char_q[$];
    t_dec_result decoded_q[$];
    int          chars_queued   = 0;
    int          chars_accepted = 0;
    int          fail_count     = 0;

    int send_gap  = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm  = 0;
    logic        send_fire;
    logic        nxt_valid;
    logic [7:0]  nxt_data;
    t_dec_result want_r;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Returns {valid, sextet}
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 52)};
        if (c == CHAR_PLUS) return {1'b1, SEXTET_PLUS};
        if (c == CHAR_SLASH) return {1'b1, SEXTET_SLASH};
        return 7'd0;
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        logic [7:0]  ch;
        logic [6:0]  lk;
        logic [5:0]  v;
        t_dec_result r;
        ch = c;
        r = '0;
        if (ch == CHAR_NUL) begin
            r.is_end = 1'b1;
            r.status = (pad_seen && (grp_phase == GRP_S0 || grp_phase == GRP_S1))
                       ? STATUS_BAD_PAD : STATUS_OK;
            decoded_q.push_back(r);
            grp_phase = GRP_S0;
            high_bits = 8'h00;
            pad_seen  = 1'b0;
            return;
        end
        if (pad_seen) return;
        if (ch == CHAR_PAD) begin
            pad_seen = 1'b1;
            return;
        end
        if (ch == CHAR_SPACE && space_as_plus) ch = CHAR_PLUS;
        lk = char_sextet(ch);
        if (!lk[6]) return;
        v = lk[5:0];
        case (grp_phase)
            GRP_S0: begin
                high_bits = {v, 2'b00};
                grp_phase = GRP_S1;
                return;
            end
            GRP_S1: begin
                r.data_byte = high_bits | {6'd0, v[5:4]};
                high_bits   = {v[3:0] & LOW_NIBBLE_MASK, 4'd0};
                grp_phase   = GRP_S2;
            end
            GRP_S2: begin
                r.data_byte = high_bits | {4'd0, v[5:2]};
                high_bits   = {v[1:0] & LOW_PAIR_MASK, 6'd0};
                grp_phase   = 2'd3;
            end
            default: begin
                r.data_byte = high_bits | {2'd0, v};
                high_bits   = 8'h00;
                grp_phase   = GRP_S0;
            end
        endcase
        decoded_q.push_back(r);
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(30, 100);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver: hold the current transfer until accepted, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end else begin
            send_fire = s_axis_tvalid && s_axis_tready;
            if (send_fire) begin
                decode_char(s_axis_tdata);
                chars_accepted++;
            end
            if (!s_axis_tvalid || send_fire) begin
                nxt_valid = 1'b0;
                nxt_data  = s_axis_tdata;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (char_q.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = char_q.pop_front();
                    send_gap  = next_gap(send_calm);
                end
                s_axis_tvalid <= nxt_valid;
                s_axis_tdata  <= nxt_data;
            end
        end
    end

    // Monitor: check each output transfer against the oldest decoded result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected output: data %h last %b user %b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want_r = decoded_q.pop_front();
                    if (m_axis_tdata !== want_r.data_byte || m_axis_tlast !== want_r.is_end
                        || m_axis_tuser !== want_r.status) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"output mismatch: expected data %h last %b user %b,",
                                      " got %h %b %b"},
                                     want_r.data_byte, want_r.is_end, want_r.status,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0) recv_stall = next_gap(recv_calm);
            end
        end
    end

    task automatic push_char(input logic [7:0] c);
        char_q.push_back(c);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [7:0] encode_sextet(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + (v - 26));
        if (v < 62) return 8'("0" + (v - 52));
        if (v == SEXTET_PLUS) return ($urandom_range(0, 1) == 0) ? CHAR_PLUS : CHAR_SPACE;
        return CHAR_SLASH;
    endfunction

    // One string: mostly valid groups with some noise and padding, sometimes raw bytes
    task automatic push_random_string();
        int n_sext;
        int pad_kind;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(1, 255)));
        end else begin
            n_sext = 4 * $urandom_range(0, 4) + $urandom_range(0, 3);
            if ($urandom_range(0, 15) == 0) n_sext = $urandom_range(16, 60);
            repeat (n_sext) begin
                if ($urandom_range(0, 9) == 0) push_char(8'($urandom_range(1, 255)));
                push_char(encode_sextet(6'($urandom_range(0, 63))));
            end
            pad_kind = $urandom_range(0, 3);
            if (pad_kind != 0) push_char(CHAR_PAD);
            if (pad_kind == 2) push_char(CHAR_PAD);
            if (pad_kind == 3)
                repeat ($urandom_range(1, 5)) push_char(8'($urandom_range(1, 255)));
        end
        push_char(CHAR_NUL);
    endtask

    // Wait until every character is taken and every result has come out
    task automatic drain();
        while (chars_accepted != chars_queued || decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_space_option(input logic v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        space_as_plus = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [0:3] cfg_plan;
        int         phase_start;
        cfg_plan = 4'b0101;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings under the reset setting (space decodes as plus)
        push_text("TWFu/+9z");
        push_char(CHAR_NUL);
        push_text("Q x");
        push_char(8'hff);
        push_text("==");
        push_char(CHAR_NUL);
        push_text("QU");
        push_char(8'h80);
        push_text("J=");
        push_char(CHAR_NUL);
        push_text("az");
        push_char(CHAR_NUL);
        push_text("=");
        push_char(CHAR_NUL);
        push_text("Z=");
        push_char(CHAR_NUL);
        drain();

        foreach (cfg_plan[p]) begin
            write_space_option(cfg_plan[p]);
            phase_start = chars_queued;
            while (chars_queued - phase_start < PHASE_ITEMS) push_random_string();
            drain();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
